[src/scntok_pkg.sv]
// ----------------------------------------------------------------------------
// scntok_pkg
// Shared types, character codes and keyword tables for the scene text
// tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package scntok_pkg;

  localparam int POS_W             = 24;
  localparam int LEN_W             = 10;
  localparam int LEN_MAX           = 1023;
  localparam int DEF_MAX_TOKEN_LEN = 1023;
  localparam int KW_NUM            = 11;
  localparam int KW_MAXLEN         = 18;
  localparam int FIFO_DEPTH        = 8;
  localparam int FIFO_AW           = 3;
  localparam int PUSH_MAX          = 2;

  localparam logic [POS_W-1:0]  POS_MAX = '1;
  localparam logic [KW_NUM-1:0] KW_ALL  = '1;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keyword text, right aligned: the first character sits in the highest used byte
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    "MaterialBinding", "value", {"PER_VERTEX", "_INDEXED"}, "Background",
    "skyColor", "Coordinate3", "point", "Material", "emissiveColor",
    "IndexedFaceSet", "coordIndex"
  };
  localparam logic [4:0] KW_LEN [KW_NUM] = '{
    5'd15, 5'd5, 5'd18, 5'd10, 5'd8, 5'd11, 5'd5, 5'd8, 5'd13, 5'd14, 5'd10
  };

  typedef enum logic [4:0] {
    TK_END, TK_LPAREN, TK_RPAREN, TK_LBRACKET, TK_RBRACKET, TK_LBRACE,
    TK_RBRACE, TK_PLUS, TK_MINUS, TK_COMMA, TK_KEYWORD, TK_NUMBER,
    TK_STRING, TK_OTHER, TK_BAD_KEYWORD, TK_BAD_NUMBER, TK_OPEN_STRING
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_NUMBER, MODE_STRING
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t         mode;
    logic [KW_NUM-1:0]  cand;
    logic [LEN_W-1:0]   run_len;
    logic [POS_W-1:0]   run_start;
    logic [POS_W-1:0]   pos;
    logic               dot;
    logic               expo;
    logic               prev_e;
    logic               qsingle;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode: MODE_IDLE, cand: KW_ALL, run_len: '0, run_start: '0, pos: '0,
    dot: 1'b0, expo: 1'b0, prev_e: 1'b0, qsingle: 1'b0
  };

  typedef struct packed {
    token_kind_t        kind;
    logic [3:0]         kw_idx;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic [7:0]         chr;
    logic               last;
  } result_t;

  // results of one byte, handed to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_hit_t;

  function automatic result_t mk_res(token_kind_t kind, logic [3:0] kw_idx,
                                     logic [POS_W-1:0] start, logic [LEN_W-1:0] len,
                                     logic [7:0] chr);
    result_t r;
    r.kind   = kind;
    r.kw_idx = kw_idx;
    r.start  = start;
    r.len    = len;
    r.chr    = chr;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic token_kind_t punct_kind(logic [7:0] b);
    token_kind_t k;
    unique case (b)
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_LBRACK: k = TK_LBRACKET;
      CH_RBRACK: k = TK_RBRACKET;
      CH_LBRACE: k = TK_LBRACE;
      CH_RBRACE: k = TK_RBRACE;
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_COMMA:  k = TK_COMMA;
      default:   k = TK_END;
    endcase
    return k;
  endfunction

  // keep the keywords whose character at run_len equals b
  function automatic logic [KW_NUM-1:0] kw_narrow(logic [KW_NUM-1:0] cand,
                                                  logic [LEN_W-1:0] run_len,
                                                  logic [7:0] b);
    logic [KW_NUM-1:0] keep;
    logic [4:0]        i;
    int                sh;
    keep = '0;
    i    = run_len[4:0];
    for (int k = 0; k < KW_NUM; k++) begin
      sh = 8 * (int'(KW_LEN[k]) - int'(i) - 1);
      if (cand[k] && run_len < LEN_W'(KW_LEN[k])) begin
        if (KW_TEXT[k][sh +: 8] == b) begin
          keep[k] = 1'b1;
        end
      end
    end
    return keep;
  endfunction

  // lowest numbered candidate whose length equals run_len
  function automatic kw_hit_t kw_match(logic [KW_NUM-1:0] cand,
                                       logic [LEN_W-1:0] run_len);
    kw_hit_t h;
    h = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (cand[k] && run_len == LEN_W'(KW_LEN[k])) begin
        h.hit = 1'b1;
        h.idx = 4'(k);
      end
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[src/scntok_core.sv]
// ----------------------------------------------------------------------------
// scntok_core
// Input register, scanner state and the per-byte token logic; yields up to
// two results for each registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scntok_core #(
  parameter int MAX_TOKEN_LEN = scntok_pkg::DEF_MAX_TOKEN_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              op,
  input  wire logic [7:0]        text_byte,
  output scntok_pkg::push_t      push
);
  import scntok_pkg::*;

  localparam int LenCap = (MAX_TOKEN_LEN < LEN_MAX) ? MAX_TOKEN_LEN : LEN_MAX;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCap);

  logic        in_vld;
  logic        in_op;
  logic [7:0]  in_byte;

  scan_state_t st, st_next;
  result_t     res [2];
  logic [1:0]  n;
  logic        again;
  logic        bad;
  logic        ext;
  logic [LEN_W-1:0] run_grow;
  kw_hit_t     hit;
  token_kind_t pk;
  result_t     id_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op   <= op;
      in_byte <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    hit      = kw_match(st.cand, st.run_len);
    pk       = punct_kind(in_byte);
    run_grow = (st.run_len < LEN_CAP) ? st.run_len + LEN_W'(1) : st.run_len;
    ext      = is_digit(in_byte) || in_byte == CH_DOT || in_byte == CH_UP_E ||
               in_byte == CH_PLUS || in_byte == CH_MINUS;
    bad      = (in_byte == CH_DOT && st.dot) || (in_byte == CH_UP_E && st.expo) ||
               ((in_byte == CH_PLUS || in_byte == CH_MINUS) && !st.prev_e);
    id_res   = hit.hit ? mk_res(TK_KEYWORD, hit.idx, st.run_start, st.run_len, '0)
                       : mk_res(TK_BAD_KEYWORD, '0, st.run_start, st.run_len, '0);

    st_next = st;
    res[0]  = mk_res(TK_END, '0, '0, '0, '0);
    res[1]  = mk_res(TK_END, '0, '0, '0, '0);
    n       = 2'd0;
    again   = 1'b0;

    if (in_vld) begin
      if (in_op) begin
        // end of text: flush the open token, then the end token
        case (st.mode)
          MODE_IDENT: begin
            res[0] = id_res;
            n      = 2'd1;
          end
          MODE_NUMBER: begin
            res[0] = mk_res(TK_NUMBER, '0, st.run_start, st.run_len, '0);
            n      = 2'd1;
          end
          MODE_STRING: begin
            res[0] = mk_res(TK_OPEN_STRING, '0, st.run_start, st.run_len, '0);
            n      = 2'd1;
          end
          default: ;
        endcase
        res[n[0]] = mk_res(TK_END, '0, st.pos, '0, '0);
        n         = n + 2'd1;
        st_next   = SCAN_RESET;
      end else begin
        case (st.mode)
          MODE_COMMENT: begin
            if (in_byte == CH_LF || in_byte == CH_CR) begin
              st_next.mode = MODE_IDLE;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER) begin
              st_next.cand    = kw_narrow(st.cand, st.run_len, in_byte);
              st_next.run_len = run_grow;
            end else begin
              res[0]       = id_res;
              n            = 2'd1;
              st_next.mode = MODE_IDLE;
              again        = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (ext && !bad) begin
              if (in_byte == CH_DOT) begin
                st_next.dot = 1'b1;
              end
              if (in_byte == CH_UP_E) begin
                st_next.expo = 1'b1;
              end
              st_next.prev_e  = (in_byte == CH_UP_E);
              st_next.run_len = run_grow;
            end else begin
              // a bad byte inside number text marks it malformed
              res[0]       = mk_res(ext ? TK_BAD_NUMBER : TK_NUMBER, '0,
                                    st.run_start, st.run_len, '0);
              n            = 2'd1;
              st_next.mode = MODE_IDLE;
              again        = 1'b1;
            end
          end
          MODE_STRING: begin
            if (in_byte == (st.qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
              res[0]       = mk_res(TK_STRING, '0, st.run_start, st.run_len, '0);
              n            = 2'd1;
              st_next.mode = MODE_IDLE;
            end else begin
              st_next.run_len = run_grow;
            end
          end
          default: begin
            st_next.mode = MODE_IDLE;
            again        = 1'b1;
          end
        endcase

        // the byte is scanned anew from idle: whitespace, a comment or a new token
        if (again) begin
          if (in_byte == CH_SPACE || in_byte == CH_TAB ||
              in_byte == CH_LF || in_byte == CH_CR) begin
            st_next.mode = MODE_IDLE;
          end else if (in_byte == CH_HASH) begin
            st_next.mode = MODE_COMMENT;
          end else if (pk != TK_END) begin
            res[n[0]] = mk_res(pk, '0, st.pos, LEN_W'(1), in_byte);
            n         = n + 2'd1;
          end else begin
            st_next.run_start = st.pos;
            if (is_alpha(in_byte)) begin
              st_next.mode    = MODE_IDENT;
              st_next.cand    = kw_narrow(KW_ALL, '0, in_byte);
              st_next.run_len = LEN_W'(1);
            end else if (is_digit(in_byte)) begin
              st_next.mode    = MODE_NUMBER;
              st_next.run_len = LEN_W'(1);
              st_next.dot     = 1'b0;
              st_next.expo    = 1'b0;
              st_next.prev_e  = 1'b0;
            end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
              st_next.mode    = MODE_STRING;
              st_next.run_len = '0;
              st_next.qsingle = (in_byte == CH_SQUOTE);
            end else begin
              res[n[0]] = mk_res(TK_OTHER, '0, st.pos, LEN_W'(1), in_byte);
              n         = n + 2'd1;
            end
          end
        end

        if (st.pos != POS_MAX) begin
          st_next.pos = st.pos + POS_W'(1);
        end
      end
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    push.cnt = n;
    push.r0  = res[0];
    push.r1  = res[1];
  end

endmodule

`default_nettype wire

[src/scntok_fifo.sv]
// ----------------------------------------------------------------------------
// scntok_fifo
// Result queue: takes zero to two results a cycle, hands out one result a
// cycle on the output channel whenever pop is set.
// ----------------------------------------------------------------------------
`default_nettype none

module scntok_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire scntok_pkg::push_t         push,
  input  wire logic                      pop,
  output scntok_pkg::result_t            head,
  output logic [scntok_pkg::FIFO_AW:0]   level
);
  import scntok_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] wr_ptr1;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr_next;
  logic [FIFO_AW-1:0] rd_ptr_next;
  logic [FIFO_AW:0]   level_next;

  assign wr_ptr1     = wr_ptr + FIFO_AW'(1);
  assign wr_ptr_next = wr_ptr + FIFO_AW'(push.cnt);
  assign rd_ptr_next = rd_ptr + FIFO_AW'(pop);
  assign level_next  = level + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

endmodule

`default_nettype wire

[src/scene_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// scene_text_tokenizer
// Byte-serial tokenizer for scene description text.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one text byte per transaction (s_tuser = 1 marks end of text,
//   the byte is then ignored). m_* carries one token per transaction; m_tlast
//   flags the last token caused by one input byte.
//   A byte accepted on s_* sits in the input register and is scanned in
//   the next cycle; its tokens are written into the output queue, from
//   which the first one shows on m_*. The input runs at one byte per
//   cycle as long as tokens drain; a byte that ends one token and is
//   itself a one-byte token (or an end of text with a pending token)
//   makes two tokens. s_tready drops while the eight-entry output queue
//   holds more than four tokens, so a stalled receiver holds tokens in
//   the queue and soon stalls the sender.
//   Reset clears the scanner to the start of a new text at offset 0 and
//   empties the queue; end of text does the same for the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_text_tokenizer #(
  parameter int MAX_TOKEN_LEN = scntok_pkg::DEF_MAX_TOKEN_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // keyword_index, token_start, token_length, char_value
  output logic [4:0]       m_tuser,   // token_kind
  output logic             m_tlast    // last_of_run
);
  import scntok_pkg::*;

  logic             s_acc;
  logic             pop;
  push_t            push;
  result_t          head;
  logic [FIFO_AW:0] level;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = level <= (FIFO_AW + 1)'(FIFO_DEPTH - 2 * PUSH_MAX);
  assign m_tvalid = level != '0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, head.chr, head.len, head.start, head.kw_idx};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  scntok_core #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_acc),
    .op        (s_tuser),
    .text_byte (s_tdata),
    .push      (push)
  );

  scntok_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser |=> push.cnt != 2'd0)
    else $error("end of text produced no token");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd3)
    else $error("more than two tokens from one byte");
`endif

endmodule

`default_nettype wire
